// File: src/wsr_pkg.sv
// ----------------------------------------------------------------------------
// wsr_pkg
// Shared types, codes and default sizes of the windowed-sinc resampler.
// ----------------------------------------------------------------------------
package wsr_pkg;

  // default sizes, overridable on the top level
  localparam int RING_DEPTH_DEF     = 256;
  localparam int TABLE_DEPTH_DEF    = 131072;
  localparam int TABLE_RES_BITS_DEF = 10;

  // fixed field widths
  localparam int MODE_W    = 2;
  localparam int TIDX_W    = 17;
  localparam int TVAL_W    = 18;
  localparam int SAMPLE_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam int STEP_W  = 26;
  localparam int GAIN_W  = 18;
  localparam int HALF_W  = 7;
  localparam int TLEN_W  = 17;
  localparam int COUNT_W = 32;
  localparam int POS_W   = 58;
  localparam int FRAC_W  = 24;

  // outputs emitted per pushed sample at most
  localparam int MAX_OUT = 64;
  localparam int NOUT_W  = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_DRAIN  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYPASS       = 3'd0,
    CFG_PHASE_STEP   = 3'd1,
    CFG_GAIN         = 3'd2,
    CFG_HALF_TAPS    = 3'd3,
    CFG_TABLE_LENGTH = 3'd4,
    CFG_OUTPUT_COUNT = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TAPS,
    ST_DRAIN,
    ST_SCALE,
    ST_ROUND,
    ST_PUSH
  } state_t;

  // configuration reset values
  localparam logic [STEP_W-1:0]  STEP_RST  = 26'd16777216;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 18'd69349;
  localparam logic [HALF_W-1:0]  HALF_RST  = 7'd34;
  localparam logic [TLEN_W-1:0]  TLEN_RST  = 17'd34678;

endpackage

// File: src/wsr_if.sv
// ----------------------------------------------------------------------------
// wsr_in_if / wsr_out_if
// Valid/ready channels carrying the input and result words of the resampler.
// ----------------------------------------------------------------------------
interface wsr_in_if;
  import wsr_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [MODE_W-1:0]           mode;
  logic [TIDX_W-1:0]           table_index;
  logic signed [TVAL_W-1:0]    table_value;
  logic signed [SAMPLE_W-1:0]  sample_in;

  modport source (output valid, mode, table_index, table_value, sample_in, input ready);
  modport sink   (input valid, mode, table_index, table_value, sample_in, output ready);
endinterface

interface wsr_out_if;
  import wsr_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  sample_out;
  logic                        out_last;

  modport source (output valid, sample_out, out_last, input ready);
  modport sink   (input valid, sample_out, out_last, output ready);
endinterface

// File: src/wsr_ram.sv
// ----------------------------------------------------------------------------
// wsr_ram
// Generic RAM: one write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module wsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: src/windowed_sinc_resampler.sv
// ----------------------------------------------------------------------------
// windowed_sinc_resampler
// Fractional-rate resampler with a linearly interpolated windowed-sinc kernel.
// ----------------------------------------------------------------------------
// Input words are handled one at a time. A table load and an ignored word are
// taken in ST_IDLE alone; a bypassed sample goes on through ST_PUSH to the
// output register. Each computed output walks 2*half_taps+2 taps, one tap per
// cycle, bounded by the kernel table memory which is read at two neighboring
// entries every cycle; then come pipeline drain, scaling, rounding and push,
// and an output released by a pushed sample first passes the window check in
// ST_CHECK. The push waits out any output stall. A pushed sample may release
// up to 64 outputs in a row. The sample ring needs no clearing after reset:
// only entries written since reset are ever used, so the block takes words as
// soon as reset is released.
module windowed_sinc_resampler
  import wsr_pkg::*;
#(
  parameter int RING_DEPTH     = RING_DEPTH_DEF,
  parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
  parameter int TABLE_RES_BITS = TABLE_RES_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsr_pkg::CFG_W-1:0]     cfg_data,
  wsr_in_if.sink                        in_ch,
  wsr_out_if.source                     out_ch
);

  import wsr_pkg::*;

  localparam int RA     = $clog2(RING_DEPTH);
  localparam int TA     = $clog2(TABLE_DEPTH);
  localparam int WBITS  = FRAC_W - TABLE_RES_BITS;
  localparam int AD_W   = 33;
  localparam int M_W    = AD_W - WBITS;
  localparam int P_W    = TVAL_W + WBITS + 2;
  localparam int PROD_W = P_W + 1 + SAMPLE_W;
  localparam int ACC_W  = PROD_W + 8;
  localparam int R_W    = ACC_W - WBITS - 2;
  localparam int LO_W   = 24;
  localparam int HI_W   = R_W - LO_W;
  localparam int TOT_W  = R_W + GAIN_W + 1;
  localparam int Y_W    = TOT_W - 31;

  localparam logic [31:0]         TDEPTH32 = 32'(TABLE_DEPTH);
  localparam logic signed [35:0]  RDEPTH_S = 36'(RING_DEPTH);
  localparam logic [RA:0]         RDM1     = (RA+1)'(RING_DEPTH - 1);
  localparam logic [RA:0]         RDEP     = (RA+1)'(RING_DEPTH);
  localparam logic [WBITS:0]      WONE     = (WBITS+1)'(1) << WBITS;

  // configuration
  logic                bypass_r;
  logic [STEP_W-1:0]   step_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [HALF_W-1:0]   half_r;
  logic [TLEN_W-1:0]   tlen_r;
  logic [COUNT_W-1:0]  ocount_r;

  // stream state
  state_t              state_r, state_nxt;
  logic [COUNT_W-1:0]  out_index_r;
  logic [POS_W-1:0]    pos_r;
  logic [COUNT_W-1:0]  in_count_r;
  logic                ended_r;
  logic [RA-1:0]       wr_ptr_r;
  logic [NOUT_W-1:0]   n_r;
  logic                once_r;
  logic                push_emit_r;
  logic [SAMPLE_W-1:0] y_r;

  // tap walk
  logic [8:0]          tap_r;
  logic [8:0]          ntaps;
  logic                s1_v_r, s1_t0ok_r, s1_t1ok_r, s1_xok_r;
  logic [WBITS-1:0]    s1_f_r;
  logic                s2_v_r;
  logic signed [P_W-1:0]      p0_r, p1_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic                s3_v_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;

  // scaling
  logic                neg_r;
  logic [LO_W+GAIN_W-1:0] lo_p_r;
  logic [HI_W+GAIN_W-1:0] hi_p_r;

  // output register
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic                out_last_r;

  logic in_acc, slot_free, ring_we, tab_we, start_emit, issue, last_issue, more_out;
  mode_t in_mode;

  assign in_mode   = mode_t'(in_ch.mode);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign ntaps     = {1'b0, half_r, 1'b0} + 9'd2;
  assign issue     = (state_r == ST_TAPS);
  assign last_issue = issue && (tap_r == ntaps - 9'd1);

  assign ring_we = in_acc && (in_mode == MODE_SAMPLE) && !ended_r && !bypass_r;
  assign tab_we  = in_acc && (in_mode == MODE_LOAD) &&
                   (32'(in_ch.table_index) < TDEPTH32);

  assign more_out = (n_r < NOUT_W'(MAX_OUT)) && (out_index_r < ocount_r) &&
                    (({1'b0, pos_r[POS_W-1:FRAC_W]} + 35'(half_r) + 35'd1) <
                     {3'b0, in_count_r});

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt  = state_r;
    start_emit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            MODE_SAMPLE: begin
              if (!ended_r) begin
                state_nxt = bypass_r ? ST_PUSH : ST_CHECK;
              end
            end
            MODE_DRAIN: begin
              if (!bypass_r && out_index_r < ocount_r) begin
                state_nxt  = ST_TAPS;
                start_emit = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (more_out) begin
          state_nxt  = ST_TAPS;
          start_emit = 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TAPS: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r && !s3_v_r) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (slot_free) begin
          state_nxt = (!push_emit_r || once_r) ? ST_IDLE : ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b0;
      step_r   <= STEP_RST;
      gain_r   <= GAIN_RST;
      half_r   <= HALF_RST;
      tlen_r   <= TLEN_RST;
      ocount_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_BYPASS:       bypass_r <= cfg_data[0];
        CFG_PHASE_STEP:   step_r   <= cfg_data[STEP_W-1:0];
        CFG_GAIN:         gain_r   <= cfg_data[GAIN_W-1:0];
        CFG_HALF_TAPS:    half_r   <= cfg_data[HALF_W-1:0];
        CFG_TABLE_LENGTH: tlen_r   <= cfg_data[TLEN_W-1:0];
        CFG_OUTPUT_COUNT: ocount_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- tap addressing
  logic signed [9:0]  jj;
  logic [8:0]         mag_j;
  logic [AD_W-1:0]    ad_base, ad;
  logic [M_W-1:0]     m;
  logic [M_W:0]       m1;
  logic               skip;
  logic signed [35:0] k_s, cnt_s, rel;
  logic               x_ok;
  logic [RA:0]        rt;
  logic [RA-1:0]      ring_raddr;

  always_comb begin
    jj      = $signed({1'b0, tap_r}) - $signed({3'b0, half_r});
    mag_j   = jj[9] ? 9'(-jj) : jj[8:0];
    ad_base = {1'b0, mag_j[7:0], 24'b0};
    // distance from the output position to the tap, always non-negative
    if (jj <= 0) begin
      ad = ad_base + AD_W'(pos_r[FRAC_W-1:0]);
    end else begin
      ad = ad_base - AD_W'(pos_r[FRAC_W-1:0]);
    end
    m    = ad[AD_W-1:WBITS];
    m1   = {1'b0, m} + (M_W+1)'(1);
    skip = (32'(m1) >= 32'(tlen_r));

    k_s   = $signed({2'b0, pos_r[POS_W-1:FRAC_W]}) + 36'(jj);
    cnt_s = $signed({4'b0, in_count_r});
    x_ok  = (k_s >= 0) && (k_s < cnt_s) && (k_s >= cnt_s - RDEPTH_S);
    rel   = cnt_s - 36'sd1 - k_s;
    // entry of sample k, counted back from the last written slot
    rt    = {1'b0, wr_ptr_r} + RDM1 - {1'b0, rel[RA-1:0]};
    ring_raddr = (rt >= RDEP) ? RA'(rt - RDEP) : rt[RA-1:0];
  end

  logic [TVAL_W-1:0]   tab_rd0, tab_rd1;
  logic [SAMPLE_W-1:0] ring_rd;

  wsr_ram #(.WIDTH(TVAL_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .we      (tab_we),
    .waddr   (TA'(in_ch.table_index)),
    .wdata   (in_ch.table_value),
    .raddr_a (TA'(m)),
    .rdata_a (tab_rd0),
    .raddr_b (TA'(m1)),
    .rdata_b (tab_rd1)
  );

  wsr_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk     (clk),
    .we      (ring_we),
    .waddr   (wr_ptr_r),
    .wdata   (in_ch.sample_in),
    .raddr_a (ring_raddr),
    .rdata_a (ring_rd),
    .raddr_b (ring_raddr),
    .rdata_b ()
  );

  // ------------------------------------------------------- tap pipeline
  logic signed [TVAL_W-1:0]  tv0, tv1;
  logic signed [WBITS+1:0]   w0, w1;
  logic signed [P_W:0]       h;

  always_comb begin
    tv0 = s1_t0ok_r ? $signed(tab_rd0) : '0;
    tv1 = s1_t1ok_r ? $signed(tab_rd1) : '0;
    w0  = $signed({1'b0, WONE - (WBITS+1)'(s1_f_r)});
    w1  = $signed({2'b0, s1_f_r});
    h   = (P_W+1)'(p0_r) + (P_W+1)'(p1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue && !skip;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_f_r    <= ad[WBITS-1:0];
    s1_t0ok_r <= 32'(m) < TDEPTH32;
    s1_t1ok_r <= 32'(m1) < TDEPTH32;
    s1_xok_r  <= x_ok;
    p0_r      <= tv0 * w0;
    p1_r      <= tv1 * w1;
    x_r       <= s1_xok_r ? $signed(ring_rd) : '0;
    prod_r    <= h * x_r;
  end

  // ------------------------------------------------------- scaling
  logic [ACC_W-1:0]       acc_mag;
  logic [ACC_W:0]         acc_rnd;
  logic [R_W-1:0]         r1;
  logic [TOT_W-1:0]       total;
  logic [TOT_W:0]         tot_rnd;
  logic [Y_W-1:0]         ymag;
  logic [SAMPLE_W-1:0]    y_sat;

  always_comb begin
    acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    acc_rnd = {1'b0, acc_mag} + ((ACC_W+1)'(1) << (WBITS + 1));
    r1      = acc_rnd[WBITS+2 +: R_W];
    total   = (TOT_W'(hi_p_r) << LO_W) + TOT_W'(lo_p_r);
    tot_rnd = {1'b0, total} + ((TOT_W+1)'(1) << 30);
    ymag    = tot_rnd[31 +: Y_W];
    // saturate to the signed 16-bit range
    if (neg_r) begin
      y_sat = (ymag > Y_W'(32768)) ? 16'h8000 : SAMPLE_W'(-ymag);
    end else begin
      y_sat = (ymag > Y_W'(32767)) ? 16'h7fff : SAMPLE_W'(ymag);
    end
  end

  // ------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_index_r <= '0;
      pos_r       <= '0;
      in_count_r  <= '0;
      ended_r     <= 1'b0;
      wr_ptr_r    <= '0;
      n_r         <= '0;
      once_r      <= 1'b0;
      push_emit_r <= 1'b0;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_IDLE && in_acc) begin
        if (in_mode == MODE_SAMPLE && !ended_r) begin
          if (bypass_r) begin
            y_r         <= in_ch.sample_in;
            push_emit_r <= 1'b0;
          end else begin
            wr_ptr_r   <= (wr_ptr_r == RA'(RING_DEPTH - 1)) ? '0 : wr_ptr_r + RA'(1);
            in_count_r <= in_count_r + 32'd1;
            n_r        <= '0;
            once_r     <= 1'b0;
          end
        end
        if (in_mode == MODE_DRAIN) begin
          ended_r <= 1'b1;
          n_r     <= '0;
          once_r  <= 1'b1;
        end
      end

      if (start_emit) begin
        tap_r       <= '0;
        acc_r       <= '0;
        push_emit_r <= 1'b1;
      end else if (issue) begin
        tap_r <= tap_r + 9'd1;
      end

      if (s3_v_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end

      if (state_r == ST_SCALE) begin
        neg_r  <= acc_r[ACC_W-1];
        lo_p_r <= r1[LO_W-1:0] * gain_r;
        hi_p_r <= r1[R_W-1:LO_W] * gain_r;
      end

      if (state_r == ST_ROUND) begin
        y_r <= y_sat;
      end

      if (state_r == ST_PUSH && slot_free) begin
        out_valid_r  <= 1'b1;
        out_sample_r <= y_r;
        out_last_r   <= (out_index_r + 32'd1) == ocount_r;
        out_index_r  <= out_index_r + 32'd1;
        if (push_emit_r) begin
          pos_r <= pos_r + POS_W'(step_r);
          n_r   <= n_r + NOUT_W'(1);
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.out_last   = out_last_r;

  // ------------------------------------------------------- assertions
  a_acc_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> (state_r == ST_TAPS || state_r == ST_DRAIN))
    else $error("tap product arrived outside the tap walk");

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCALE) |-> (!s1_v_r && !s2_v_r && !s3_v_r))
    else $error("scaling started before the tap pipeline drained");

  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAPS) |-> (tap_r < ntaps))
    else $error("tap counter ran past the window");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH && slot_free) |=> out_valid_r)
    else $error("result word lost on push");

endmodule
